### hw/rtl/grouped_weighted_quantile_select_assert.svh
// assertion macros for the grouped weighted quantile select block
`ifndef GROUPED_WEIGHTED_QUANTILE_SELECT_ASSERT_SVH
`define GROUPED_WEIGHTED_QUANTILE_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GWQS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("gwqs check failed");
`define GWQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gwqs sequence check failed");
`else
`define GWQS_ASSERT(lbl, clk, rstn, prop)
`define GWQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/gwqs_pkg.sv
// types and constants of the grouped weighted quantile select block
`timescale 1ns / 1ps
`default_nettype none
package gwqs_pkg;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VAL_W      = 32;
    localparam int RES_W      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_QFRAC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USEW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GCOUNT = 3'd4;

    localparam logic [1:0] MODE_TIES  = 2'd0;
    localparam logic [1:0] MODE_LOWER = 2'd1;
    localparam logic [1:0] MODE_UPPER = 2'd2;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef enum logic [12:0] {
        S_LOAD  = 13'b0000000000001,
        S_GRP   = 13'b0000000000010,
        S_STAT  = 13'b0000000000100,
        S_PREP  = 13'b0000000001000,
        S_OUT   = 13'b0000000010000,
        S_OWAIT = 13'b0000000100000,
        S_IN    = 13'b0000001000000,
        S_CLS   = 13'b0000010000000,
        S_FIN   = 13'b0000100000000,
        S_ABS   = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_SIGN  = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;
endpackage
`default_nettype wire

### hw/rtl/grouped_weighted_quantile_select.sv
// Loads up to MAX_ITEMS samples one per cycle into an item memory with one write and one read
// port; after the item flagged last it works through the groups in order and hands out one
// quantile per group. Each group costs a statistics pass over the memory, then a visit to
// every stored item, plus for each member of the group a full pass over the memory that counts
// its rank and preceding weight, plus a bit-serial division in weighted mode; the one read
// port of the item memory sets this cost.
// The block takes no new item until the last group result has been transferred.
`timescale 1ns / 1ps
`default_nettype none
`include "grouped_weighted_quantile_select_assert.svh"
module grouped_weighted_quantile_select #(
    parameter int MAX_ITEMS  = 1024,
    parameter int MAX_GROUPS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gwqs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gwqs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [gwqs_pkg::VAL_W-1:0] i_sample_value,
    input  logic                              i_sample_missing,
    input  logic [5:0]                        i_group_id,
    input  logic [15:0]                       i_sample_weight,
    input  logic                              i_last_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [5:0]                        o_result_group,
    output logic signed [gwqs_pkg::RES_W-1:0] o_result_value,
    output logic [1:0]                        o_result_status,
    output logic                              o_result_last
);
    import gwqs_pkg::*;

    localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int WW   = CW + 16;
    localparam int TW   = WW + 16;
    localparam int NPW  = CW + 16;
    localparam int SW   = VAL_W + CW;
    localparam int DVW  = SW + 8;
    localparam int BITW = $clog2(DVW + 1);
    localparam int MEMW = VAL_W + 6 + 16 + 1;

    // item memory: value, group, weight, missing
    logic [MEMW-1:0] mem [MAX_ITEMS];
    logic [MEMW-1:0] r_rd_data;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;

    t_state r_state;
    logic [15:0] r_qfrac;
    logic [1:0]  r_tie;
    logic        r_drop;
    logic        r_usew;
    logic [6:0]  r_gcount;

    logic [CW-1:0]         r_count;
    logic [MAX_GROUPS-1:0] r_seen;
    logic [MAX_GROUPS-1:0] r_hmiss;
    logic [GW-1:0]         r_g;
    logic [CW-1:0]         r_addr;
    logic [CW-1:0]         r_e;
    logic [CW-1:0]         r_n;
    logic [WW-1:0]         r_wsum;
    logic [CW-1:0]         r_nth;
    logic [TW-1:0]         r_tgt;
    logic signed [VAL_W-1:0] r_cv;
    logic [AW-1:0]         r_ce;
    logic [CW-1:0]         r_rank;
    logic [WW-1:0]         r_pre;
    logic signed [VAL_W-1:0] r_a;
    logic signed [VAL_W-1:0] r_b;
    logic                  r_have;
    logic [CW-1:0]         r_brank;
    logic signed [VAL_W-1:0] r_bv;
    logic signed [SW-1:0]  r_rsum;
    logic [CW-1:0]         r_rcnt;
    logic signed [SW-1:0]  r_num;
    logic [CW-1:0]         r_div;
    logic [CW-1:0]         r_rem;
    logic [DVW-1:0]        r_quo;
    logic [BITW-1:0]       r_bit;
    logic                  r_neg;
    logic signed [RES_W-1:0] r_res;
    logic [1:0]            r_status;

    logic [6:0]  ng;
    logic [1:0]  mode;
    logic        store_ok;
    logic        scan;
    logic        issue;
    logic [AW-1:0] rd_addr;
    logic signed [VAL_W-1:0] rd_val;
    logic [5:0]  rd_grp;
    logic [15:0] rd_w;
    logic        rd_miss;
    logic        member;
    logic        key_lt;
    logic        last_g;
    logic [NPW-1:0] nprod;
    logic [TW-1:0]  s_val;
    logic        s_lt;
    logic        s_eq;
    logic        taken;
    logic signed [VAL_W:0] sum_ab;
    logic [SW-1:0]  mag;
    logic [CW:0]    rem_sh;
    logic           rem_ge;
    logic [RES_W-1:0] quo_lo;

    always_comb begin
        if (r_gcount == 7'd0) begin
            ng = 7'd1;
        end else if (r_gcount > 7'(MAX_GROUPS)) begin
            ng = 7'(MAX_GROUPS);
        end else begin
            ng = r_gcount;
        end
    end

    assign mode     = (r_tie > MODE_UPPER) ? MODE_UPPER : r_tie;
    assign store_ok = ({1'b0, i_group_id} < ng) && (r_count < CW'(MAX_ITEMS));
    assign scan     = (r_state == S_STAT) || (r_state == S_IN);
    assign issue    = (scan && (r_addr < r_count)) || ((r_state == S_OUT) && (r_e < r_count));
    assign rd_addr  = (r_state == S_OUT) ? r_e[AW-1:0] : r_addr[AW-1:0];

    assign rd_val  = r_rd_data[MEMW-1 -: VAL_W];
    assign rd_grp  = r_rd_data[22:17];
    assign rd_w    = r_rd_data[16:1];
    assign rd_miss = r_rd_data[0];
    assign member  = (rd_grp == 6'(r_g)) && !rd_miss;
    // sort key is value, then store position
    assign key_lt  = member && ((rd_val < r_cv) || ((rd_val == r_cv) && (r_rd_idx < r_ce)));
    assign last_g  = (7'(r_g) == (ng - 7'd1));

    assign nprod  = NPW'((mode == MODE_UPPER) ? r_n : (r_n - 1'b1)) * NPW'(r_qfrac);
    assign s_val  = {r_pre, 16'h0000};
    assign s_lt   = s_val < r_tgt;
    assign s_eq   = s_val == r_tgt;
    assign taken  = s_lt || ((mode == MODE_UPPER) && s_eq);
    assign sum_ab = (VAL_W + 1)'(r_a) + (VAL_W + 1)'(r_b);
    assign mag    = r_num[SW-1] ? SW'(-r_num) : SW'(r_num);
    assign rem_sh = {r_rem, r_quo[DVW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};
    assign quo_lo = r_quo[RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if ((r_state == S_LOAD) && i_valid && store_ok) begin
            mem[r_count[AW-1:0]] <= {i_sample_value, i_group_id, i_sample_weight,
                                     i_sample_missing};
        end
        r_rd_data <= mem[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_seen   <= '0;
            r_hmiss  <= '0;
            r_rd_vld <= 1'b0;
            r_qfrac  <= 16'd32768;
            r_tie    <= MODE_TIES;
            r_drop   <= 1'b1;
            r_usew   <= 1'b0;
            r_gcount <= 7'd1;
        end else begin
            r_rd_vld <= issue;
            if (issue && scan) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_QFRAC:  r_qfrac  <= i_cfg_data;
                    CFG_TIE:    r_tie    <= i_cfg_data[1:0];
                    CFG_DROP:   r_drop   <= i_cfg_data[0];
                    CFG_USEW:   r_usew   <= i_cfg_data[0];
                    CFG_GCOUNT: r_gcount <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (store_ok) begin
                            r_count <= r_count + 1'b1;
                            r_seen[i_group_id[GW-1:0]] <= 1'b1;
                            if (i_sample_missing) begin
                                r_hmiss[i_group_id[GW-1:0]] <= 1'b1;
                            end
                        end
                        if (i_last_item) begin
                            r_g     <= '0;
                            r_state <= S_GRP;
                        end
                    end
                end
                S_GRP: begin
                    r_res <= '0;
                    if (!r_seen[r_g]) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_EMIT;
                    end else if (!r_drop && r_hmiss[r_g]) begin
                        r_status <= ST_MISSING;
                        r_state  <= S_EMIT;
                    end else begin
                        r_n     <= '0;
                        r_wsum  <= '0;
                        r_addr  <= '0;
                        r_state <= S_STAT;
                    end
                end
                S_STAT: begin
                    if (r_rd_vld && member) begin
                        r_n    <= r_n + 1'b1;
                        r_wsum <= r_wsum + WW'(rd_w);
                    end
                    if (!issue && !r_rd_vld) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_nth  <= nprod[NPW-1:16];
                    r_tgt  <= TW'(r_wsum) * TW'(r_qfrac);
                    r_have <= 1'b0;
                    r_rsum <= '0;
                    r_rcnt <= '0;
                    r_e    <= '0;
                    if ((r_n == '0) || (r_usew && (r_wsum == '0))) begin
                        r_status <= ST_MISSING;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= (r_e < r_count) ? S_OWAIT : S_FIN;
                end
                S_OWAIT: begin
                    if (member) begin
                        r_cv    <= rd_val;
                        r_ce    <= r_rd_idx;
                        r_rank  <= '0;
                        r_pre   <= '0;
                        r_addr  <= '0;
                        r_state <= S_IN;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_IN: begin
                    if (r_rd_vld && key_lt) begin
                        r_rank <= r_rank + 1'b1;
                        r_pre  <= r_pre + WW'(rd_w);
                    end
                    if (!issue && !r_rd_vld) begin
                        r_state <= S_CLS;
                    end
                end
                S_CLS: begin
                    if (!r_usew) begin
                        if (r_rank == r_nth) begin
                            r_a <= r_cv;
                        end
                        if ({1'b0, r_rank} == ({1'b0, r_nth} + 1'b1)) begin
                            r_b <= r_cv;
                        end
                    end else begin
                        if (taken && (!r_have || (r_rank >= r_brank))) begin
                            r_have  <= 1'b1;
                            r_brank <= r_rank;
                            r_bv    <= r_cv;
                        end
                        // values sitting exactly on the target join the tie run
                        if ((mode == MODE_TIES) && s_eq) begin
                            r_rsum <= r_rsum + SW'(r_cv);
                            r_rcnt <= r_rcnt + 1'b1;
                        end
                    end
                    r_e     <= r_e + 1'b1;
                    r_state <= S_OUT;
                end
                S_FIN: begin
                    if (!r_usew) begin
                        r_status <= ST_VALID;
                        if ((mode == MODE_TIES) && !r_n[0]
                            && (({1'b0, r_nth} + 1'b1) < {1'b0, r_n})) begin
                            r_res <= {sum_ab, 7'b0};
                        end else begin
                            r_res <= {r_a, 8'h00};
                        end
                        r_state <= S_EMIT;
                    end else if (!r_have) begin
                        r_status <= ST_MISSING;
                        r_state  <= S_EMIT;
                    end else begin
                        r_num   <= SW'(r_bv) + r_rsum;
                        r_div   <= r_rcnt + 1'b1;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_num[SW-1];
                    r_quo   <= {mag, 8'h00};
                    r_rem   <= '0;
                    r_bit   <= BITW'(DVW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= rem_ge ? CW'(rem_sh - {1'b0, r_div}) : CW'(rem_sh);
                    r_quo <= {r_quo[DVW-2:0], rem_ge};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == BITW'(1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    r_res    <= r_neg ? -quo_lo : quo_lo;
                    r_status <= ST_VALID;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_ready) begin
                        if (last_g) begin
                            r_count <= '0;
                            r_seen  <= '0;
                            r_hmiss <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_g     <= r_g + 1'b1;
                            r_state <= S_GRP;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = (r_state == S_LOAD);
    assign o_valid         = (r_state == S_EMIT);
    assign o_result_group  = 6'(r_g);
    assign o_result_value  = r_res;
    assign o_result_status = r_status;
    assign o_result_last   = last_g;

    `GWQS_ASSERT(a_load_emit_excl, i_clk, i_rst_n, !(o_ready && o_valid))
    `GWQS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_ITEMS))
    `GWQS_ASSERT_NEXT(a_run_cleared, i_clk, i_rst_n, o_valid && i_ready && o_result_last, o_ready && (r_count == '0) && (r_seen == '0))
    `GWQS_ASSERT_NEXT(a_scan_no_rd, i_clk, i_rst_n, (r_state == S_OUT) && (r_e >= r_count), !r_rd_vld)
endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the grouped weighted quantile select block
`timescale 1ns / 1ps
module testbench;
    import gwqs_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               missing;
        logic [5:0]         gid;
        logic [15:0]        weight;
        logic               last;
    } t_sample;

    typedef struct {
        logic [5:0]         grp;
        logic signed [39:0] value;
        logic [1:0]         status;
        logic               last;
    } t_quant;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_sample               s;
        bit                    typed;
        t_quant                want;
    } t_row;

    localparam int MAX_ITEMS  = 1024;
    localparam int MAX_GROUPS = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [31:0]    i_sample_value = '0;
    logic                  i_sample_missing = 1'b0;
    logic [5:0]            i_group_id = '0;
    logic [15:0]           i_sample_weight = '0;
    logic                  i_last_item = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [5:0]            o_result_group;
    logic signed [39:0]    o_result_value;
    logic [1:0]            o_result_status;
    logic                  o_result_last;

    grouped_weighted_quantile_select dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register shadow
    logic [15:0] q_frac = 16'd32768;
    logic [1:0]  tie_sel = MODE_TIES;
    logic        drop_miss = 1'b1;
    logic        weighted = 1'b0;
    logic [6:0]  grp_cnt = 7'd1;

    // run contents held for the quantile predictor
    logic signed [31:0] val_mem[MAX_ITEMS];
    logic [5:0]         grp_mem[MAX_ITEMS];
    logic [15:0]        wt_mem[MAX_ITEMS];
    logic               miss_mem[MAX_ITEMS];
    int                 stored = 0;
    int                 grp_tally[MAX_GROUPS];
    bit                 grp_missing[MAX_GROUPS];

    t_quant pending_q[$];
    int     errors = 0;
    int     results_seen = 0;
    int     samples_sent = 0;
    int     runs_done = 0;
    bit     burst = 0;
    int     hold_req = 0;
    t_row   rows[$];

    function automatic int predict_quantiles(t_sample s, output t_quant res[MAX_GROUPS]);
        int eff, mode, n, i, j, g, nth, cnt_run;
        int sel[MAX_ITEMS];
        longint unsigned q, total, cum, tgt, sh;
        longint v, run_sum;
        bit have, ok;
        logic [1:0] st;
        eff = (grp_cnt == 0) ? 1 : (grp_cnt > MAX_GROUPS) ? MAX_GROUPS : int'(grp_cnt);
        mode = (tie_sel == 2'd3) ? MODE_UPPER : tie_sel;
        q = q_frac;
        if (s.gid < eff && stored < MAX_ITEMS) begin
            val_mem[stored] = s.value;
            grp_mem[stored] = s.gid;
            wt_mem[stored] = s.weight;
            miss_mem[stored] = s.missing;
            stored++;
            grp_tally[s.gid]++;
            if (s.missing) grp_missing[s.gid] = 1;
        end
        if (!s.last) return 0;
        for (g = 0; g < eff; g++) begin
            v = 0;
            if (grp_tally[g] == 0) begin
                st = ST_EMPTY;
            end else if (!drop_miss && grp_missing[g]) begin
                st = ST_MISSING;
            end else begin
                // stable insertion sort of the group's present values
                n = 0;
                for (i = 0; i < stored; i++) begin
                    if (grp_mem[i] == g && !miss_mem[i]) begin
                        j = n;
                        while (j > 0 && val_mem[sel[j-1]] > val_mem[i]) begin
                            sel[j] = sel[j-1];
                            j--;
                        end
                        sel[j] = i;
                        n++;
                    end
                end
                ok = 0;
                if (n > 0 && !weighted) begin
                    ok = 1;
                    if (mode == MODE_UPPER) nth = int'((longint'(n) * q) >> 16);
                    else nth = int'((longint'(n - 1) * q) >> 16);
                    if (nth > n - 1) nth = n - 1;
                    if (mode == MODE_TIES && n % 2 == 0 && nth + 1 < n)
                        v = (longint'(val_mem[sel[nth]]) + longint'(val_mem[sel[nth+1]])) * 128;
                    else
                        v = longint'(val_mem[sel[nth]]) * 256;
                end else if (n > 0) begin
                    total = 0;
                    for (i = 0; i < n; i++) total += wt_mem[sel[i]];
                    if (total != 0) begin
                        tgt = total * q;
                        cum = 0;
                        have = 0;
                        run_sum = 0;
                        cnt_run = 0;
                        ok = 1;
                        for (i = 0; i < n; i++) begin
                            sh = cum << 16;
                            if (mode == MODE_LOWER && sh >= tgt) break;
                            if (mode == MODE_UPPER && sh > tgt) break;
                            if (mode == MODE_TIES && sh > tgt) break;
                            if (mode == MODE_TIES && sh == tgt) begin
                                // tied run with nothing taken yet gives no value
                                if (!have) begin
                                    ok = 0;
                                    break;
                                end
                                run_sum += longint'(val_mem[sel[i]]);
                                cnt_run++;
                            end else begin
                                run_sum = longint'(val_mem[sel[i]]);
                                cnt_run = 1;
                                have = 1;
                            end
                            cum += wt_mem[sel[i]];
                        end
                        if (!have) ok = 0;
                        if (ok) v = (run_sum * 256) / cnt_run;
                    end
                end
                st = ok ? ST_VALID : ST_MISSING;
                if (!ok) v = 0;
            end
            res[g].grp = g[5:0];
            res[g].value = v[39:0];
            res[g].status = st;
            res[g].last = (g == eff - 1);
        end
        stored = 0;
        for (g = 0; g < MAX_GROUPS; g++) begin
            grp_tally[g] = 0;
            grp_missing[g] = 0;
        end
        return eff;
    endfunction

    task automatic send_sample(t_sample s, bit typed, t_quant want);
        int gap, n, k;
        t_quant res[MAX_GROUPS];
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_value <= s.value;
        i_sample_missing <= s.missing;
        i_group_id <= s.gid;
        i_sample_weight <= s.weight;
        i_last_item <= s.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        samples_sent++;
        n = predict_quantiles(s, res);
        if (n > 0) runs_done++;
        if (typed && n > 0) pending_q.push_back(want);
        else for (k = 0; k < n; k++) pending_q.push_back(res[k]);
    endtask

    // stop offering and let the block go quiet before touching registers
    task automatic drain_results();
        i_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_QFRAC:  q_frac = data;
            CFG_TIE:    tie_sel = data[1:0];
            CFG_DROP:   drop_miss = data[0];
            CFG_USEW:   weighted = data[0];
            CFG_GCOUNT: grp_cnt = data[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_sample mk(longint v, bit m, int g, int w, bit l);
        t_sample s;
        s.value = v[31:0];
        s.missing = m;
        s.gid = g[5:0];
        s.weight = w[15:0];
        s.last = l;
        return s;
    endfunction

    task automatic add_item(longint v, bit m, int g, int w, bit l);
        t_row r;
        r = '{default: '0};
        r.s = mk(v, m, g, w, l);
        rows.push_back(r);
    endtask

    task automatic add_known(longint v, bit m, int g, longint want, logic [1:0] st);
        t_row r;
        r = '{default: '0};
        r.s = mk(v, m, g, 1, 1'b1);
        r.typed = 1;
        r.want.grp = '0;
        r.want.value = want[39:0];
        r.want.status = st;
        r.want.last = 1'b1;
        rows.push_back(r);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1;
        r.idx = idx;
        r.data = data[15:0];
        rows.push_back(r);
    endtask

    function automatic t_sample rand_sample(int eff, bit l);
        t_sample s;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) s.value = $signed($urandom_range(0, 6)) - 3;
        else if (pick < 38) s.value = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        else s.value = $urandom;
        s.missing = ($urandom_range(0, 9) == 0);
        s.gid = ($urandom_range(0, 11) == 0) ? 6'($urandom) : 6'($urandom_range(0, eff - 1));
        pick = $urandom_range(0, 9);
        if (pick < 2) s.weight = 0;
        else if (pick < 3) s.weight = 16'hffff;
        else if (pick < 7) s.weight = $urandom_range(1, 9);
        else s.weight = $urandom;
        s.last = l;
        return s;
    endfunction

    // result side: random stalls plus an occasional long hold-off
    initial begin
        int stall;
        t_quant e;
        @(posedge i_rst_n);
        forever begin
            if (hold_req > 0) begin
                i_ready <= 1'b0;
                while (hold_req > 0) begin
                    @(posedge i_clk);
                    hold_req--;
                end
            end
            stall = burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            results_seen++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: group %0d value %0d status %0d",
                             o_result_group, o_result_value, o_result_status);
            end else begin
                e = pending_q.pop_front();
                if (o_result_group !== e.grp || o_result_value !== e.value ||
                    o_result_status !== e.status || o_result_last !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp grp %0d val %0d st %0d last %0d, got %0d %0d %0d %0d",
                                 e.grp, e.value, e.status, e.last, o_result_group,
                                 o_result_value, o_result_status, o_result_last);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int g, p, k, sz, eff, done;
        t_quant none;
        none = '{default: '0};
        for (g = 0; g < MAX_GROUPS; g++) begin
            grp_tally[g] = 0;
            grp_missing[g] = 0;
        end

        // reset settings: median, ties averaged, missing dropped, one group
        add_known(10, 0, 0, 2560, ST_VALID);
        add_item(32'h7fffffff, 0, 0, 1, 0);
        add_known(32'h7fffffff, 0, 0, 64'sd549755813632, ST_VALID);
        add_known(-64'sd2147483648, 0, 0, -64'sd549755813888, ST_VALID);
        add_known(5, 1, 0, 0, ST_MISSING);
        add_known(7, 0, 63, 0, ST_EMPTY);
        // tie mode three acts as upper, top quantile
        add_cfg(CFG_TIE, 3);
        add_cfg(CFG_QFRAC, 65535);
        add_item(1, 0, 0, 1, 0);
        add_item(2, 0, 0, 1, 0);
        add_item(3, 0, 0, 1, 1);
        // weighted, zero quantile: tied run at start, zero total weight
        add_cfg(CFG_TIE, MODE_TIES);
        add_cfg(CFG_QFRAC, 0);
        add_cfg(CFG_USEW, 1);
        add_cfg(CFG_GCOUNT, 2);
        add_item(5, 0, 0, 1, 0);
        add_item(6, 0, 0, 1, 0);
        add_item(9, 0, 1, 0, 1);
        // missing kept, group count zero acts as one
        add_cfg(CFG_DROP, 0);
        add_cfg(CFG_GCOUNT, 0);
        add_item(4, 1, 0, 3, 0);
        add_item(8, 0, 0, 3, 1);
        // oversized group count clamps to the maximum
        add_cfg(CFG_GCOUNT, 127);
        add_cfg(CFG_TIE, MODE_LOWER);
        add_item(-3, 0, 0, 2, 0);
        add_item(12, 0, 63, 65535, 1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                drain_results();
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                send_sample(rows[r].s, rows[r].typed, rows[r].want);
            end
        end

        for (p = 0; p < 14; p++) begin
            drain_results();
            case (p % 5)
                0: write_reg(CFG_QFRAC, 1);
                1: write_reg(CFG_QFRAC, 65535);
                2: write_reg(CFG_QFRAC, 0);
                default: write_reg(CFG_QFRAC, $urandom_range(1, 65535));
            endcase
            write_reg(CFG_TIE, $urandom_range(0, 3));
            write_reg(CFG_DROP, $urandom_range(0, 1));
            write_reg(CFG_USEW, (p % 2 == 0) ? 1 : 0);
            case (p % 7)
                0: write_reg(CFG_GCOUNT, 64);
                1: write_reg(CFG_GCOUNT, 1);
                2: write_reg(CFG_GCOUNT, 127);
                default: write_reg(CFG_GCOUNT, $urandom_range(1, 8));
            endcase
            eff = (grp_cnt == 0) ? 1 : (grp_cnt > MAX_GROUPS) ? MAX_GROUPS : int'(grp_cnt);
            if (eff > 16) eff = 16;
            burst = (p == 3 || p == 9);
            // block keeps offered items waiting while results are held back
            if (p == 6) hold_req = 600;
            done = 0;
            while (done < 20) begin
                sz = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
                for (k = 0; k < sz; k++)
                    send_sample(rand_sample(eff, k == sz - 1), 0, none);
                done += sz;
            end
            burst = 0;
        end

        drain_results();
        $display("ran %0d items in %0d data sets, checked %0d group results",
                 samples_sent, runs_done, results_seen);
        $display("covered every tie mode, weighted and rank rules, missing handling and group limits");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
